/* rtl/fase_pkg.sv */
// Shared types and constants of the FFT analytic signal engine.
package fase_pkg;

  // Default sizes
  localparam int MAX_LOG2_SIZE_DEF = 10;
  localparam int TWIDDLE_WIDTH_DEF = 16;

  // Configuration port
  localparam int CFG_DATA_W = 4;
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LOG2_SIZE = 1'd0;
  localparam cfg_idx_t CFG_MODE      = 1'd1;
  localparam logic [3:0] LOG2_SIZE_RST = 4'd10;

  // Transform modes
  localparam logic [1:0] MODE_FWD = 2'd0;
  localparam logic [1:0] MODE_INV = 2'd1;
  localparam logic [1:0] MODE_ANA = 2'd2;
  localparam logic [1:0] MODE_RST = MODE_ANA;

  // Command functions
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // 2*pi in Q29 for the twiddle series
  localparam longint unsigned TWO_PI_Q29 = 64'd3373259426;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         position;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic [31:0]        envelope;
  } res_t;

endpackage

/* rtl/fase_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fase_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fft_analytic_signal_engine_top.sv */
// Top level of the FFT analytic signal engine: sequencer, shared multiplier, twiddle table.
//
// Commands are taken when start_i is high and busy_o low; each gives one result word on
// res_o, marked by done_o for one cycle, which the receiver must take at once. After a
// load the engine stays idle and the next command may follow straight away. A read
// captures the store entry, squares both parts on the shared 32x32 multiplier, runs 32
// steps of the bit-pair square root and registers the result word. A run on n = 2^lg
// points makes one pass over the n entries for the bit-reversed reorder, swapping each
// pair once, then forms each twiddle and runs the n/2 * lg butterflies on the one
// multiplier, which serves four products per butterfly. The analytic signal mode runs two
// transforms and adds a sweep for the spectrum weighting and one for the final scaling.
// After reset the store is cleared, one entry a cycle, over all 2^MAX_LOG2_SIZE entries
// with busy_o high; configuration writes are taken at any time and must only be made
// while the engine is idle.
module fft_analytic_signal_engine_top #(
  parameter int MAX_LOG2_SIZE = fase_pkg::MAX_LOG2_SIZE_DEF,
  parameter int TWIDDLE_WIDTH = fase_pkg::TWIDDLE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  fase_pkg::cfg_idx_t          cfg_idx_i,
  input  logic [fase_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                        start_i,
  input  fase_pkg::cmd_t              cmd_i,
  output logic                        busy_o,
  output logic                        done_o,
  output fase_pkg::res_t              res_o
);
  import fase_pkg::*;

  localparam int AW     = MAX_LOG2_SIZE;
  localparam int DEPTH  = 1 << AW;
  localparam int CNT_W  = AW + 1;
  localparam int LG_W   = $clog2(MAX_LOG2_SIZE + 1);
  localparam int TWF    = TWIDDLE_WIDTH - 1;
  localparam int ACC_W  = 32 + TWIDDLE_WIDTH + 1;
  localparam int OCT    = ((1 << MAX_LOG2_SIZE) >> 3) + 1;
  localparam int IDX_W  = (OCT > 1) ? $clog2(OCT) : 1;
  localparam int ROM_D  = 1 << IDX_W;

  typedef logic [ROM_D-1:0][2*TWF-1:0] tw_rom_t;

  // Quarter-wave twiddle table: rounded sine and cosine per angle step up to pi/4
  function automatic tw_rom_t build_rom();
    tw_rom_t         rom;
    longint unsigned one, r, x, x2, t, s, c, qs, qc, lim, half;
    int              m;
    one  = 64'd1 << 31;
    lim  = (64'd1 << TWF) - 64'd1;
    half = 64'd1 << (31 - TWF - 1);
    for (m = 0; m < ROM_D; m++) begin
      r  = longint'(m) << (32 - MAX_LOG2_SIZE);
      x  = (r * TWO_PI_Q29 + (64'd1 << 29)) >> 30;
      x2 = (x * x + (64'd1 << 30)) >> 31;
      t  = one;
      t  = one - ((x2 * t) >> 31) / 110;
      t  = one - ((x2 * t) >> 31) / 72;
      t  = one - ((x2 * t) >> 31) / 42;
      t  = one - ((x2 * t) >> 31) / 20;
      t  = one - ((x2 * t) >> 31) / 6;
      s  = (x * t) >> 31;
      t  = one;
      t  = one - ((x2 * t) >> 31) / 132;
      t  = one - ((x2 * t) >> 31) / 90;
      t  = one - ((x2 * t) >> 31) / 56;
      t  = one - ((x2 * t) >> 31) / 30;
      t  = one - ((x2 * t) >> 31) / 12;
      t  = one - ((x2 * t) >> 31) / 2;
      c  = t;
      qs = (s + half) >> (31 - TWF);
      qc = (c + half) >> (31 - TWF);
      if (qs > lim) qs = lim;
      if (qc > lim) qc = lim;
      rom[m] = {qs[TWF-1:0], qc[TWF-1:0]};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_rom();

  // Saturate a 33-bit sum to 32 bits
  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

  // Saturate a shifted product sum to 32 bits
  function automatic logic [31:0] sat_acc(input logic [ACC_W-1:0] v);
    if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31]) begin
      return v[31:0];
    end
    return v[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_CAP, S_MG0, S_MG1, S_MG2, S_SQRT,
    S_REV, S_SW_A, S_SW_B, S_SW_C, S_TW,
    S_BF_RU, S_BF_RV, S_BF_CAP, S_BF_M0, S_BF_M1, S_BF_M2, S_BF_M3, S_BF_M4,
    S_BF_RND, S_BF_WU, S_BF_WV, S_POST, S_POST_W, S_SHIFT, S_SHIFT_W
  } state_e;

  state_e             state_q, state_d;
  logic [3:0]         log2_size_q;
  logic [1:0]         mode_q;
  logic [CNT_W-1:0]   i_q, i_d, j_q, j_d, b_q, b_d;
  logic [LG_W-1:0]    slg_q, slg_d, lg_q, lg_d;
  logic               inv_q, inv_d, ana_q, ana_d;
  logic               done_q, done_d;
  res_t               res_q, res_d;

  // Datapath registers
  logic [63:0]             u_q, u_d, v_q, v_d;
  logic signed [63:0]      prod_q;
  logic signed [ACC_W-1:0] acc_r_q, acc_r_d, acc_i_q, acc_i_d;
  logic [31:0]             pr_q, pr_d, pi_q, pi_d;
  logic [TWIDDLE_WIDTH-1:0] wr_q, wr_d, wi_q, wi_d;
  logic [63:0]             rem_q, rem_d, root_q, root_d, bit_q, bit_d;

  // Store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  fase_ram #(
    .Width (64),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic signed [31:0] u_re, u_im, v_re, v_im, rd_re, rd_im;
  assign u_re  = u_q[63:32];
  assign u_im  = u_q[31:0];
  assign v_re  = v_q[63:32];
  assign v_im  = v_q[31:0];
  assign rd_re = ram_rdata[63:32];
  assign rd_im = ram_rdata[31:0];

  // Loop bounds and bit-reversed index
  logic [CNT_W-1:0] n_pts, half, two_half, rev, b_step;
  logic [AW-1:0]    rev_full;
  always_comb begin
    n_pts    = CNT_W'(1) << lg_q;
    half     = CNT_W'(1) << (slg_q - LG_W'(1));
    two_half = half << 1;
    b_step   = b_q + two_half;
    for (int k = 0; k < AW; k++) begin
      rev_full[k] = i_q[AW-1-k];
    end
    rev = CNT_W'(rev_full) >> (AW - int'(lg_q));
  end

  // Twiddle: octant reduction onto the quarter-wave table
  logic [31:0]          tw_p;
  logic [29:0]          tw_r, tw_m;
  logic                 tw_neg, tw_swap;
  logic [2*TWF-1:0]     tw_ent;
  logic [TWF-1:0]       tw_bs, tw_bc, tw_c, tw_s;
  always_comb begin
    tw_p    = 32'(j_q) << (6'd32 - 6'(slg_q));
    tw_neg  = tw_p[30];
    tw_r    = tw_p[29:0];
    tw_swap = tw_r > 30'h2000_0000;
    tw_m    = tw_swap ? 30'(31'h4000_0000 - {1'b0, tw_r}) : tw_r;
    tw_ent  = TW_ROM[IDX_W'(tw_m >> (32 - MAX_LOG2_SIZE))];
    tw_bs   = tw_swap ? tw_ent[TWF-1:0] : tw_ent[2*TWF-1:TWF];
    tw_bc   = tw_swap ? tw_ent[2*TWF-1:TWF] : tw_ent[TWF-1:0];
    tw_c    = tw_neg ? tw_bs : tw_bc;
    tw_s    = tw_neg ? tw_bc : tw_bs;
  end

  // Shared multiplier operands
  logic signed [31:0] mul_a, mul_b, wr_ext, wi_ext;
  assign wr_ext = 32'(signed'(wr_q));
  assign wi_ext = 32'(signed'(wi_q));

  // Rounded, shifted products
  logic [ACC_W-1:0] rnd_r, rnd_i;
  assign rnd_r = ACC_W'(acc_r_q + (ACC_W'(1) << (TWF - 1))) >>> TWF;
  assign rnd_i = ACC_W'(acc_i_q + (ACC_W'(1) << (TWF - 1))) >>> TWF;

  // Square root step
  logic [63:0] sq_trial;
  assign sq_trial = root_q + bit_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    b_d       = b_q;
    slg_d     = slg_q;
    lg_d      = lg_q;
    inv_d     = inv_q;
    ana_d     = ana_q;
    done_d    = 1'b0;
    res_d     = res_q;
    u_d       = u_q;
    v_d       = v_q;
    acc_r_d   = acc_r_q;
    acc_i_d   = acc_i_q;
    pr_d      = pr_q;
    pi_d      = pi_q;
    wr_d      = wr_q;
    wi_d      = wi_q;
    rem_d     = rem_q;
    root_d    = root_q;
    bit_d     = bit_q;
    mul_a     = v_re;
    mul_b     = wr_ext;
    ram_we    = 1'b0;
    ram_waddr = i_q[AW-1:0];
    ram_wdata = '0;
    ram_raddr = i_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        i_d    = i_q + CNT_W'(1);
        if (i_q == CNT_W'(DEPTH - 1)) begin
          i_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = AW'(cmd_i.position);
        ram_waddr = AW'(cmd_i.position);
        ram_wdata = {32'(cmd_i.sample_re), 32'(cmd_i.sample_im)};
        if (start_i) begin
          res_d = '0;
          case (cmd_i.func)
            FUNC_LOAD: begin
              ram_we = 1'b1;
              done_d = 1'b1;
            end
            FUNC_RUN: begin
              if (mode_q == MODE_FWD || mode_q == MODE_INV || mode_q == MODE_ANA) begin
                inv_d   = mode_q == MODE_INV;
                ana_d   = mode_q == MODE_ANA;
                i_d     = '0;
                state_d = S_REV;
                if (log2_size_q == 4'd0) begin
                  lg_d = LG_W'(1);
                end else if (int'(log2_size_q) > MAX_LOG2_SIZE) begin
                  lg_d = LG_W'(MAX_LOG2_SIZE);
                end else begin
                  lg_d = LG_W'(log2_size_q);
                end
              end else begin
                done_d = 1'b1;
              end
            end
            FUNC_READ: state_d = S_RD_CAP;
            default:   done_d  = 1'b1;
          endcase
        end
      end
      // Read: capture entry, square both parts, root of the sum
      S_RD_CAP: begin
        u_d     = ram_rdata;
        state_d = S_MG0;
      end
      S_MG0: begin
        mul_a   = u_re;
        mul_b   = u_re;
        state_d = S_MG1;
      end
      S_MG1: begin
        mul_a   = u_im;
        mul_b   = u_im;
        rem_d   = prod_q;
        state_d = S_MG2;
      end
      S_MG2: begin
        rem_d   = rem_q + prod_q;
        root_d  = '0;
        bit_d   = 64'h4000_0000_0000_0000;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (rem_q >= sq_trial) begin
          rem_d  = rem_q - sq_trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 64'd1) begin
          res_d.out_re   = u_re;
          res_d.out_im   = u_im;
          res_d.envelope = root_d[31:0];
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      // Bit-reversed reorder: swap each pair once
      S_REV: begin
        if (i_q == n_pts) begin
          slg_d   = LG_W'(1);
          j_d     = '0;
          b_d     = '0;
          state_d = S_TW;
        end else if (rev > i_q) begin
          state_d = S_SW_A;
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end
      S_SW_A: begin
        u_d       = ram_rdata;
        ram_raddr = rev[AW-1:0];
        state_d   = S_SW_B;
      end
      S_SW_B: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_d   = S_SW_C;
      end
      S_SW_C: begin
        ram_we    = 1'b1;
        ram_waddr = rev[AW-1:0];
        ram_wdata = u_q;
        i_d       = i_q + CNT_W'(1);
        state_d   = S_REV;
      end
      // Butterfly passes
      S_TW: begin
        wr_d    = tw_neg ? -{1'b0, tw_c} : {1'b0, tw_c};
        wi_d    = inv_q ? {1'b0, tw_s} : -{1'b0, tw_s};
        state_d = S_BF_RU;
      end
      S_BF_RU: begin
        ram_raddr = b_q[AW-1:0];
        state_d   = S_BF_RV;
      end
      S_BF_RV: begin
        u_d       = ram_rdata;
        ram_raddr = AW'(b_q + half);
        state_d   = S_BF_CAP;
      end
      S_BF_CAP: begin
        v_d     = ram_rdata;
        state_d = S_BF_M0;
      end
      S_BF_M0: begin
        state_d = S_BF_M1;
      end
      S_BF_M1: begin
        mul_a   = v_im;
        mul_b   = wi_ext;
        acc_r_d = prod_q[ACC_W-1:0];
        state_d = S_BF_M2;
      end
      S_BF_M2: begin
        mul_b   = wi_ext;
        acc_r_d = acc_r_q - prod_q[ACC_W-1:0];
        state_d = S_BF_M3;
      end
      S_BF_M3: begin
        mul_a   = v_im;
        acc_i_d = prod_q[ACC_W-1:0];
        state_d = S_BF_M4;
      end
      S_BF_M4: begin
        acc_i_d = acc_i_q + prod_q[ACC_W-1:0];
        state_d = S_BF_RND;
      end
      S_BF_RND: begin
        pr_d    = sat_acc(rnd_r);
        pi_d    = sat_acc(rnd_i);
        state_d = S_BF_WU;
      end
      S_BF_WU: begin
        ram_we    = 1'b1;
        ram_waddr = b_q[AW-1:0];
        ram_wdata = {sat33({u_re[31], u_re} + {pr_q[31], pr_q}),
                     sat33({u_im[31], u_im} + {pi_q[31], pi_q})};
        state_d   = S_BF_WV;
      end
      S_BF_WV: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(b_q + half);
        ram_wdata = {sat33({u_re[31], u_re} - {pr_q[31], pr_q}),
                     sat33({u_im[31], u_im} - {pi_q[31], pi_q})};
        if (b_step < n_pts) begin
          b_d     = b_step;
          state_d = S_BF_RU;
        end else if (j_q + CNT_W'(1) < half) begin
          j_d     = j_q + CNT_W'(1);
          b_d     = j_q + CNT_W'(1);
          state_d = S_TW;
        end else if (slg_q < lg_q) begin
          slg_d   = slg_q + LG_W'(1);
          j_d     = '0;
          b_d     = '0;
          state_d = S_TW;
        end else if (ana_q && !inv_q) begin
          i_d     = CNT_W'(1);
          state_d = S_POST;
        end else if (ana_q) begin
          i_d     = '0;
          state_d = S_SHIFT;
        end else begin
          res_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      // Spectrum weighting: double the lower half, drop the upper bins
      S_POST: begin
        if (i_q <= (n_pts >> 1)) begin
          state_d = S_POST_W;
        end else begin
          ram_we = 1'b1;
          i_d    = i_q + CNT_W'(1);
          if (i_q + CNT_W'(1) == n_pts) begin
            i_d     = '0;
            inv_d   = 1'b1;
            state_d = S_REV;
          end
        end
      end
      S_POST_W: begin
        ram_we    = 1'b1;
        ram_wdata = {sat33({rd_re, 1'b0}), sat33({rd_im, 1'b0})};
        i_d       = i_q + CNT_W'(1);
        state_d   = S_POST;
        if (i_q + CNT_W'(1) == n_pts) begin
          i_d     = '0;
          inv_d   = 1'b1;
          state_d = S_REV;
        end
      end
      // Final scaling by the transform length
      S_SHIFT: begin
        state_d = S_SHIFT_W;
      end
      S_SHIFT_W: begin
        ram_we    = 1'b1;
        ram_wdata = {32'(rd_re >>> lg_q), 32'(rd_im >>> lg_q)};
        i_d       = i_q + CNT_W'(1);
        state_d   = S_SHIFT;
        if (i_q + CNT_W'(1) == n_pts) begin
          res_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, configuration and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      log2_size_q <= LOG2_SIZE_RST;
      mode_q      <= MODE_RST;
      i_q         <= '0;
      j_q         <= '0;
      b_q         <= '0;
      slg_q       <= LG_W'(1);
      lg_q        <= LG_W'(1);
      inv_q       <= 1'b0;
      ana_q       <= 1'b0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      b_q     <= b_d;
      slg_q   <= slg_d;
      lg_q    <= lg_d;
      inv_q   <= inv_d;
      ana_q   <= ana_d;
      done_q  <= done_d;
      res_q   <= res_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LOG2_SIZE: log2_size_q <= cfg_data_i;
          CFG_MODE:      mode_q      <= cfg_data_i[1:0];
          default:       ;
        endcase
      end
    end
  end

  // Datapath registers and the shared multiplier
  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    v_q     <= v_d;
    prod_q  <= mul_a * mul_b;
    acc_r_q <= acc_r_d;
    acc_i_q <= acc_i_d;
    pr_q    <= pr_d;
    pi_q    <= pi_d;
    wr_q    <= wr_d;
    wi_q    <= wi_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // A load answers in the next cycle with an all-zero word
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i.func == FUNC_LOAD
    |=> done_o && res_o.out_re == 0 && res_o.out_im == 0 && res_o.envelope == 0)
    else $error("load did not return a zero word");

  // A read keeps the engine busy and gives no word in the next cycle
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i.func == FUNC_READ |=> busy_o && !done_o)
    else $error("read did not occupy the engine");

  // While idle the store is written only by an accepted load
  a_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && ram_we |-> start_i && cmd_i.func == FUNC_LOAD)
    else $error("stray store write while idle");
`endif

endmodule

/* tb/sv/fft_analytic_signal_engine_top_tb.sv */
// Testbench for the FFT analytic signal engine: command driver, result monitor, predictor.
`timescale 1ns / 1ps

module fft_analytic_signal_engine_top_tb;
  import fase_pkg::*;

  localparam int STORE_DEPTH = 1 << MAX_LOG2_SIZE_DEF;
  localparam int TW_FRAC = TWIDDLE_WIDTH_DEF - 1;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0] MODE_NONE = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_idx_t cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic start_i;
  cmd_t cmd_i;
  logic busy_o;
  logic done_o;
  res_t res_o;

  fft_analytic_signal_engine_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .start_i(start_i), .cmd_i(cmd_i), .busy_o(busy_o),
    .done_o(done_o), .res_o(res_o)
  );

  // Predictor state
  int store_re[STORE_DEPTH];
  int store_im[STORE_DEPTH];
  logic [3:0] size_cfg;
  logic [1:0] mode_cfg;

  cmd_t cmd_pending[$];
  res_t res_expected[$];
  bit cmd_taken;
  bit quiet;
  int gap_left;
  int errors;
  int unsigned cycles;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Q31 sine and cosine of an angle in the first octant
  function automatic void trig_base(input longint unsigned r,
                                    output longint unsigned s, output longint unsigned c);
    longint unsigned x, x2, t;
    int sd[5] = '{110, 72, 42, 20, 6};
    int cd[6] = '{132, 90, 56, 30, 12, 2};
    x = (r * TWO_PI_Q29 + (64'd1 << 29)) >> 30;
    x2 = (x * x + (64'd1 << 30)) >> 31;
    t = 64'd1 << 31;
    for (int i = 0; i < 5; i++) t = (64'd1 << 31) - ((x2 * t) >> 31) / sd[i];
    s = (x * t) >> 31;
    t = 64'd1 << 31;
    for (int i = 0; i < 6; i++) t = (64'd1 << 31) - ((x2 * t) >> 31) / cd[i];
    c = t;
  endfunction

  function automatic longint tw_round(longint unsigned v);
    longint unsigned q;
    q = (v + (64'd1 << (30 - TW_FRAC))) >> (31 - TW_FRAC);
    return (q > (64'd1 << TW_FRAC) - 1) ? (64'sd1 << TW_FRAC) - 1 : longint'(q);
  endfunction

  function automatic void twiddle(input int lg, input int k, input bit inv,
                                  output longint wr, output longint wi);
    longint unsigned p, r, s, c, bs, bc;
    bit neg_cos;
    p = longint'(k) << (32 - lg);
    neg_cos = p >= (64'd1 << 30);
    r = neg_cos ? p - (64'd1 << 30) : p;
    if (r <= (64'd1 << 29)) trig_base(r, bs, bc);
    else trig_base((64'd1 << 30) - r, bc, bs);
    if (neg_cos) begin
      c = bs;
      s = bc;
    end else begin
      c = bc;
      s = bs;
    end
    wr = neg_cos ? -tw_round(c) : tw_round(c);
    wi = inv ? tw_round(s) : -tw_round(s);
  endfunction

  // In-place radix-2 transform over the first 2^lg entries
  function automatic void fft_in_place(int lg, bit inv);
    int n, rev, half, tmp;
    longint wr, wi, pr, pim, ur, ui, vr, vi;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      rev = 0;
      for (int b = 0; b < lg; b++) rev |= ((i >> b) & 1) << (lg - 1 - b);
      if (rev > i) begin
        tmp = store_re[i]; store_re[i] = store_re[rev]; store_re[rev] = tmp;
        tmp = store_im[i]; store_im[i] = store_im[rev]; store_im[rev] = tmp;
      end
    end
    for (int slg = 1; slg <= lg; slg++) begin
      half = 1 << (slg - 1);
      for (int j = 0; j < half; j++) begin
        twiddle(slg, j, inv, wr, wi);
        for (int b = j; b < n; b += 2 * half) begin
          ur = store_re[b];
          ui = store_im[b];
          vr = store_re[b + half];
          vi = store_im[b + half];
          pr = sat32((vr * wr - vi * wi + (64'sd1 << (TW_FRAC - 1))) >>> TW_FRAC);
          pim = sat32((vr * wi + vi * wr + (64'sd1 << (TW_FRAC - 1))) >>> TW_FRAC);
          store_re[b] = sat32(ur + pr);
          store_im[b] = sat32(ui + pim);
          store_re[b + half] = sat32(ur - pr);
          store_im[b + half] = sat32(ui - pim);
        end
      end
    end
  endfunction

  function automatic int unsigned root64(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return int'(acc);
  endfunction

  // Apply one command to the predicted store and return the expected word
  function automatic res_t engine_result(cmd_t c);
    res_t r;
    int lg, n;
    longint re, im;
    r = '0;
    case (c.func)
      FUNC_LOAD: begin
        store_re[c.position] = c.sample_re;
        store_im[c.position] = c.sample_im;
      end
      FUNC_RUN: begin
        lg = (size_cfg < 1) ? 1 : (size_cfg > MAX_LOG2_SIZE_DEF) ? MAX_LOG2_SIZE_DEF : size_cfg;
        n = 1 << lg;
        if (mode_cfg == MODE_FWD) fft_in_place(lg, 1'b0);
        else if (mode_cfg == MODE_INV) fft_in_place(lg, 1'b1);
        else if (mode_cfg == MODE_ANA) begin
          fft_in_place(lg, 1'b0);
          for (int i = 1; i < n; i++) begin
            if (i <= n / 2) begin
              store_re[i] = sat32(2 * longint'(store_re[i]));
              store_im[i] = sat32(2 * longint'(store_im[i]));
            end else begin
              store_re[i] = 0;
              store_im[i] = 0;
            end
          end
          fft_in_place(lg, 1'b1);
          for (int i = 0; i < n; i++) begin
            store_re[i] = store_re[i] >>> lg;
            store_im[i] = store_im[i] >>> lg;
          end
        end
      end
      FUNC_READ: begin
        re = store_re[c.position];
        im = store_im[c.position];
        r.out_re = 32'(re);
        r.out_im = 32'(im);
        r.envelope = root64(longint'(re * re) + longint'(im * im));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Accept commands, predict, check result words, count cycles
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[fft_analytic_signal_engine_top] ERROR");
      $finish;
    end
    cmd_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) res_expected.push_back(engine_result(cmd_i));
    if (rst_ni && done_o) begin
      if (res_expected.size() == 0) begin
        $display("%0t: unexpected word %h", $time, res_o);
        errors++;
      end else begin
        if (res_o !== res_expected[0]) begin
          $display("%0t: mismatch expected re %0d im %0d env %0d, got re %0d im %0d env %0d",
                   $time, res_expected[0].out_re, res_expected[0].out_im,
                   res_expected[0].envelope, res_o.out_re, res_o.out_im, res_o.envelope);
          errors++;
        end
        void'(res_expected.pop_front());
      end
    end
  end

  // Drive commands from the pending queue, with random gaps
  always @(negedge clk_i) begin
    if (cmd_taken) begin
      void'(cmd_pending.pop_front());
      if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 10);
    end
    if (gap_left > 0) begin
      gap_left--;
      start_i <= 1'b0;
    end else if (cmd_pending.size() > (cmd_taken ? 0 : 0) && rst_ni) begin
      start_i <= 1'b1;
      cmd_i <= cmd_pending[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_cmd(logic [1:0] f, int pos, logic [15:0] sre, logic [15:0] sim);
    cmd_t c;
    c.func = f;
    c.position = 10'(pos);
    c.sample_re = sre;
    c.sample_im = sim;
    cmd_pending.push_back(c);
  endfunction

  task automatic wait_idle();
    while (cmd_pending.size() != 0 || res_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LOG2_SIZE) size_cfg = val;
    else mode_cfg = val[1:0];
  endtask

  task automatic set_up(logic [3:0] lg, logic [1:0] md);
    wait_idle();
    write_reg(CFG_LOG2_SIZE, lg);
    write_reg(CFG_MODE, {2'b00, md});
  endtask

  // Mostly load-run-read sequences over the active size, some noise
  task automatic random_phase(int count, bit big);
    int n, k;
    n = 1 << ((size_cfg < 1) ? 1 : (size_cfg > 10) ? 10 : size_cfg);
    while (count > 0) begin
      if (big) begin
        for (int i = 0; i < 40; i++) add_cmd(FUNC_LOAD, $urandom_range(0, n - 1),
                                             pick_sample(), pick_sample());
        add_cmd(FUNC_RUN, $urandom, pick_sample(), pick_sample());
        for (int i = 0; i < 40; i++) add_cmd(FUNC_READ, $urandom_range(0, 1023), '0, '0);
        count = 0;
      end else if ($urandom_range(0, 9) < 6) begin
        k = (n < 16) ? n : $urandom_range(4, 16);
        for (int i = 0; i < n; i++)
          if (i < k || $urandom_range(0, 3) == 0)
            add_cmd(FUNC_LOAD, i, pick_sample(), pick_sample());
        add_cmd(FUNC_RUN, $urandom, 16'($urandom), 16'($urandom));
        for (int i = 0; i < k; i++) add_cmd(FUNC_READ, $urandom_range(0, n - 1), '0, '0);
        count -= 2 * k + 1;
      end else begin
        add_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                16'($urandom), 16'($urandom));
        count--;
      end
    end
  endtask

  initial begin
    int sizes[12] = '{1, 2, 4, 5, 6, 0, 3, 2, 6, 1, 4, 5};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LOG2_SIZE;
    cfg_data_i = '0;
    start_i = 1'b0;
    cmd_i = '0;
    cmd_taken = 1'b0;
    quiet = 1'b0;
    gap_left = 0;
    errors = 0;
    cycles = 0;
    size_cfg = LOG2_SIZE_RST;
    mode_cfg = MODE_RST;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_re[i] = 0;
      store_im[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every function, entries past the active size
    set_up(4'd3, MODE_FWD);
    add_cmd(FUNC_READ, 5, '0, '0);
    add_cmd(FUNC_LOAD, 0, 16'h7fff, 16'h7fff);
    add_cmd(FUNC_LOAD, 1, 16'h8000, 16'h8000);
    add_cmd(FUNC_LOAD, 2, 16'h7fff, 16'h8000);
    add_cmd(FUNC_LOAD, 3, 16'hffff, 16'h0001);
    add_cmd(FUNC_LOAD, 1023, 16'h8000, 16'h7fff);
    add_cmd(FUNC_NONE, 1023, 16'hffff, 16'hffff);
    add_cmd(FUNC_RUN, 0, '0, '0);
    for (int i = 0; i < 8; i++) add_cmd(FUNC_READ, i, '0, '0);
    add_cmd(FUNC_READ, 1023, '0, '0);
    add_cmd(FUNC_READ, 1023, 16'hffff, 16'hffff);
    set_up(4'd3, MODE_NONE);
    add_cmd(FUNC_RUN, 0, '0, '0);
    add_cmd(FUNC_READ, 0, '0, '0);

    // Random phases across sizes and modes, then the largest sizes
    foreach (sizes[p]) begin
      set_up(4'(sizes[p]), 2'($urandom_range(0, 3)));
      random_phase(90, 1'b0);
    end
    set_up(4'd10, MODE_ANA);
    random_phase(1, 1'b1);
    set_up(4'd15, MODE_INV);
    random_phase(1, 1'b1);

    // Last part without gaps
    set_up(4'd4, MODE_ANA);
    quiet = 1'b1;
    random_phase(80, 1'b0);
    wait_idle();
    if (errors == 0) begin
      $display("[fft_analytic_signal_engine_top] OK");
    end else begin
      $display("[fft_analytic_signal_engine_top] ERROR");
    end
    $finish;
  end

endmodule

/* fft_analytic_signal_engine_top.f */
rtl/fase_pkg.sv
rtl/fase_ram.sv
rtl/fft_analytic_signal_engine_top.sv
tb/sv/fft_analytic_signal_engine_top_tb.sv
